>>> hdl/mre_pkg.sv
`timescale 1ns / 1ps
// Package for the execute unit: beat types, opcode and function codes,
// control structs. Depends on nothing.
package mre_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned RegIdxW = 5;
    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned CntW    = 5;

    localparam logic [CfgIdxW-1:0] CfgCause = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgEpc   = 1'd1;

    localparam logic [WordW-1:0] SignBit     = 32'h8000_0000;
    localparam logic [WordW-1:0] AllOnes     = 32'hFFFF_FFFF;
    localparam logic [WordW-1:0] SegmentMask = 32'hF000_0000;
    localparam logic [WordW-1:0] NoCopReg    = 32'hDEAD_BEEF;
    localparam int unsigned      IsolateBit  = 16;

    localparam logic [5:0] OpSpecial = 6'h00;
    localparam logic [5:0] OpRegimm  = 6'h01;
    localparam logic [5:0] OpJ       = 6'h02;
    localparam logic [5:0] OpJal     = 6'h03;
    localparam logic [5:0] OpBeq     = 6'h04;
    localparam logic [5:0] OpBne     = 6'h05;
    localparam logic [5:0] OpBlez    = 6'h06;
    localparam logic [5:0] OpBgtz    = 6'h07;
    localparam logic [5:0] OpAddi    = 6'h08;
    localparam logic [5:0] OpAddiu   = 6'h09;
    localparam logic [5:0] OpSlti    = 6'h0A;
    localparam logic [5:0] OpSltiu   = 6'h0B;
    localparam logic [5:0] OpAndi    = 6'h0C;
    localparam logic [5:0] OpOri     = 6'h0D;
    localparam logic [5:0] OpLui     = 6'h0F;
    localparam logic [5:0] OpCop0    = 6'h10;
    localparam logic [5:0] OpLb      = 6'h20;
    localparam logic [5:0] OpLw      = 6'h23;
    localparam logic [5:0] OpLbu     = 6'h24;
    localparam logic [5:0] OpSb      = 6'h28;
    localparam logic [5:0] OpSh      = 6'h29;
    localparam logic [5:0] OpSw      = 6'h2B;

    localparam logic [5:0] FnSll     = 6'h00;
    localparam logic [5:0] FnSrl     = 6'h02;
    localparam logic [5:0] FnSra     = 6'h03;
    localparam logic [5:0] FnJr      = 6'h08;
    localparam logic [5:0] FnJalr    = 6'h09;
    localparam logic [5:0] FnSyscall = 6'h0C;
    localparam logic [5:0] FnMfhi    = 6'h10;
    localparam logic [5:0] FnMflo    = 6'h12;
    localparam logic [5:0] FnDiv     = 6'h1A;
    localparam logic [5:0] FnDivu    = 6'h1B;
    localparam logic [5:0] FnAdd     = 6'h20;
    localparam logic [5:0] FnAddu    = 6'h21;
    localparam logic [5:0] FnSubu    = 6'h23;
    localparam logic [5:0] FnAnd     = 6'h24;
    localparam logic [5:0] FnOr      = 6'h25;
    localparam logic [5:0] FnSlt     = 6'h2A;
    localparam logic [5:0] FnSltu    = 6'h2B;

    localparam logic [4:0] CopMf     = 5'h00;
    localparam logic [4:0] CopMt     = 5'h04;
    localparam logic [4:0] CopStatus = 5'd12;
    localparam logic [4:0] CopCause  = 5'd13;
    localparam logic [4:0] CopEpc    = 5'd14;
    localparam logic [4:0] LinkReg   = 5'd31;

    localparam logic [1:0] WrNone    = 2'd0;
    localparam logic [1:0] WrNow     = 2'd1;
    localparam logic [1:0] WrDelayed = 2'd2;

    localparam logic [2:0] MemNone = 3'd0;
    localparam logic [2:0] MemLb   = 3'd1;
    localparam logic [2:0] MemLbu  = 3'd2;
    localparam logic [2:0] MemLw   = 3'd3;
    localparam logic [2:0] MemSb   = 3'd4;
    localparam logic [2:0] MemSh   = 3'd5;
    localparam logic [2:0] MemSw   = 3'd6;

    typedef struct packed {
        logic [WordW-1:0] instr_word;
        logic [WordW-1:0] rs_value;
        logic [WordW-1:0] rt_value;
        logic [WordW-1:0] next_pc;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         reg_write;
        logic [RegIdxW-1:0] dest_index;
        logic [WordW-1:0]   dest_value;
        logic [2:0]         mem_op;
        logic [WordW-1:0]   mem_address;
        logic [WordW-1:0]   store_data;
        logic [WordW-1:0]   new_next_pc;
        logic               unhandled;
    } t_out_beat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

>>> hdl/mre_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for instruction beats and result beats.
// Depends on mre_pkg.
interface mre_in_if;
    logic              valid;
    logic              ready;
    mre_pkg::t_in_beat beat;
    modport source (output valid, output beat, input ready);
    modport sink (input valid, input beat, output ready);
endinterface

interface mre_out_if;
    logic               valid;
    logic               ready;
    mre_pkg::t_out_beat beat;
    modport source (output valid, output beat, input ready);
    modport sink (input valid, input beat, output ready);
endinterface

>>> hdl/mre_divider.sv
`timescale 1ns / 1ps
// Restoring radix-2 divider on magnitudes, one quotient bit per cycle,
// with sign fix-up on the outputs. Depends on mre_pkg.
module mre_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mre_pkg::WordW-1:0]   i_dividend,
    input  logic [mre_pkg::WordW-1:0]   i_divisor,
    input  logic                        i_neg_quot,
    input  logic                        i_neg_rem,
    output mre_pkg::t_div_status        o_status,
    output logic [mre_pkg::WordW-1:0]   o_quot,
    output logic [mre_pkg::WordW-1:0]   o_rem
);
    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [mre_pkg::CntW-1:0]     r_cnt, n_cnt;
    logic [mre_pkg::WordW-1:0]    r_rem, n_rem;
    logic [mre_pkg::WordW-1:0]    r_quo, n_quo;
    logic [mre_pkg::WordW-1:0]    r_div;
    logic                         r_nq, r_nr;
    logic [mre_pkg::WordW+1:0]    trial;

    assign trial = {1'b0, r_rem, r_quo[mre_pkg::WordW-1]} - {2'b00, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            if (!trial[mre_pkg::WordW+1]) begin
                n_rem = trial[mre_pkg::WordW-1:0];
                n_quo = {r_quo[mre_pkg::WordW-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[mre_pkg::WordW-2:0], r_quo[mre_pkg::WordW-1]};
                n_quo = {r_quo[mre_pkg::WordW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == '1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_div <= i_divisor;
            r_nq  <= i_neg_quot;
            r_nr  <= i_neg_rem;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot = r_nq ? (~r_quo + 1'b1) : r_quo;
    assign o_rem  = r_nr ? (~r_rem + 1'b1) : r_rem;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a preceding busy cycle");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider did not go busy after start");
endmodule

>>> hdl/mips_r3000_execute_unit.sv
`timescale 1ns / 1ps
// Top level of the execute unit: decode, execution, HI/LO, status and result
// register. Depends on mre_pkg, mre_if and mre_divider.
//
// Usage: instruction beats arrive on i_in with the rs and rt register values
// and the next-fetch address; one result beat per instruction leaves on o_out.
// The cause and exception pc values are written through i_cfg_we, i_cfg_index
// and i_cfg_data; the user must write them only while the unit is idle; the
// unit does not enforce this. A result is registered, so it appears in the
// cycle after its instruction beat is accepted. DIV and DIVU with a non-zero
// divisor and no overflow run the shared restoring divider, one quotient bit
// per cycle; the next instruction waits until the divider has produced every
// quotient bit and signalled completion. Any other instruction can be followed
// by another in the next cycle while results are taken. A divide's own result
// beat is issued at once; HI and LO are written when the divider completes.
// Reset clears HI, LO, the status word, both configuration values and the
// result valid flag. When the receiver stalls, the result register holds its
// beat and a new instruction is taken only in the cycle the result is taken.
module mips_r3000_execute_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mre_in_if.sink                        i_in,
    mre_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [mre_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [mre_pkg::WordW-1:0]     i_cfg_data
);
    logic [mre_pkg::WordW-1:0] r_hi, n_hi, r_lo, n_lo;
    logic [mre_pkg::WordW-1:0] r_status, r_cause, r_epc;
    logic                      r_out_valid;
    mre_pkg::t_out_beat        r_out, res;
    logic                      accept, hilo_we, div_start;
    mre_pkg::t_div_status      div_st;
    logic [mre_pkg::WordW-1:0] div_q, div_r;

    logic [mre_pkg::WordW-1:0] iw, rsv, rtv, npc, simm, imm, btarget, jtarget;
    logic [mre_pkg::WordW-1:0] sum_imm, abs_n, abs_d;
    logic [5:0]                op, fn;
    logic [4:0]                rs, rt, rd, sh;
    logic                      is_div, is_divu, nneg, dneg, ovf;

    assign iw   = i_in.beat.instr_word;
    assign rsv  = i_in.beat.rs_value;
    assign rtv  = i_in.beat.rt_value;
    assign npc  = i_in.beat.next_pc;
    assign op   = iw[31:26];
    assign rs   = iw[25:21];
    assign rt   = iw[20:16];
    assign rd   = iw[15:11];
    assign sh   = iw[10:6];
    assign fn   = iw[5:0];
    assign imm  = {16'h0000, iw[15:0]};
    assign simm = {{16{iw[15]}}, iw[15:0]};
    assign btarget = npc + {simm[29:0], 2'b00} - 32'd4;
    assign jtarget = (npc & mre_pkg::SegmentMask) | {4'h0, iw[25:0], 2'b00};
    assign sum_imm = rsv + simm;

    assign is_div  = (op == mre_pkg::OpSpecial) && (fn == mre_pkg::FnDiv);
    assign is_divu = (op == mre_pkg::OpSpecial) && (fn == mre_pkg::FnDivu);
    assign nneg = rsv[31] && is_div;
    assign dneg = rtv[31] && is_div;
    assign ovf  = is_div && (rsv == mre_pkg::SignBit) && (rtv == mre_pkg::AllOnes);
    assign abs_n = nneg ? (~rsv + 1'b1) : rsv;
    assign abs_d = dneg ? (~rtv + 1'b1) : rtv;

    assign i_in.ready = !div_st.busy && !div_st.done && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;
    assign div_start  = accept && (is_div || is_divu) && (rtv != '0) && !ovf;

    always_comb begin
        res = '0;
        res.new_next_pc = npc;
        case (op)
            mre_pkg::OpSpecial: begin
                res.reg_write  = mre_pkg::WrNow;
                res.dest_index = rd;
                case (fn)
                    mre_pkg::FnSll: res.dest_value = rtv << sh;
                    mre_pkg::FnSrl: res.dest_value = rtv >> sh;
                    mre_pkg::FnSra: res.dest_value = $unsigned($signed(rtv) >>> sh);
                    mre_pkg::FnJr: begin
                        res.reg_write   = mre_pkg::WrNone;
                        res.dest_index  = '0;
                        res.new_next_pc = rsv;
                    end
                    mre_pkg::FnJalr: begin
                        res.dest_value  = npc;
                        res.new_next_pc = rsv;
                    end
                    mre_pkg::FnSyscall, mre_pkg::FnDiv, mre_pkg::FnDivu: begin
                        res.reg_write  = mre_pkg::WrNone;
                        res.dest_index = '0;
                    end
                    mre_pkg::FnMfhi: res.dest_value = r_hi;
                    mre_pkg::FnMflo: res.dest_value = r_lo;
                    mre_pkg::FnAdd, mre_pkg::FnAddu: res.dest_value = rsv + rtv;
                    mre_pkg::FnSubu: res.dest_value = rsv - rtv;
                    mre_pkg::FnAnd:  res.dest_value = rsv & rtv;
                    mre_pkg::FnOr:   res.dest_value = rsv | rtv;
                    mre_pkg::FnSlt:
                        res.dest_value = {31'd0, $signed(rsv) < $signed(rtv)};
                    mre_pkg::FnSltu: res.dest_value = {31'd0, rsv < rtv};
                    default: begin
                        res.reg_write  = mre_pkg::WrNone;
                        res.dest_index = '0;
                        res.unhandled  = 1'b1;
                    end
                endcase
            end
            mre_pkg::OpRegimm: begin
                if (iw[20]) begin
                    res.reg_write  = mre_pkg::WrNow;
                    res.dest_index = mre_pkg::LinkReg;
                    res.dest_value = npc;
                end
                if (rsv[31] != iw[16]) res.new_next_pc = btarget;
            end
            mre_pkg::OpJal: begin
                res.reg_write   = mre_pkg::WrNow;
                res.dest_index  = mre_pkg::LinkReg;
                res.dest_value  = npc;
                res.new_next_pc = jtarget;
            end
            mre_pkg::OpJ: res.new_next_pc = jtarget;
            mre_pkg::OpBeq: if (rsv == rtv) res.new_next_pc = btarget;
            mre_pkg::OpBne: if (rsv != rtv) res.new_next_pc = btarget;
            mre_pkg::OpBlez: if (rsv[31] || rsv == '0) res.new_next_pc = btarget;
            mre_pkg::OpBgtz: if (!rsv[31] && rsv != '0) res.new_next_pc = btarget;
            mre_pkg::OpAddi, mre_pkg::OpAddiu, mre_pkg::OpSlti, mre_pkg::OpSltiu,
            mre_pkg::OpAndi, mre_pkg::OpOri, mre_pkg::OpLui: begin
                res.reg_write  = mre_pkg::WrNow;
                res.dest_index = rt;
                case (op)
                    mre_pkg::OpSlti:
                        res.dest_value = {31'd0, $signed(rsv) < $signed(simm)};
                    mre_pkg::OpSltiu: res.dest_value = {31'd0, rsv < simm};
                    mre_pkg::OpAndi:  res.dest_value = rsv & imm;
                    mre_pkg::OpOri:   res.dest_value = rsv | imm;
                    mre_pkg::OpLui:   res.dest_value = {iw[15:0], 16'h0000};
                    default:          res.dest_value = sum_imm;
                endcase
            end
            mre_pkg::OpCop0: begin
                if (rs == mre_pkg::CopMf) begin
                    res.reg_write  = mre_pkg::WrDelayed;
                    res.dest_index = rt;
                    case (rd)
                        mre_pkg::CopStatus: res.dest_value = r_status;
                        mre_pkg::CopCause:  res.dest_value = r_cause;
                        mre_pkg::CopEpc:    res.dest_value = r_epc;
                        default:            res.dest_value = mre_pkg::NoCopReg;
                    endcase
                end else if (rs != mre_pkg::CopMt) begin
                    res.unhandled = 1'b1;
                end
            end
            mre_pkg::OpLb, mre_pkg::OpLw, mre_pkg::OpLbu,
            mre_pkg::OpSb, mre_pkg::OpSh, mre_pkg::OpSw: begin
                if (!r_status[mre_pkg::IsolateBit]) begin
                    res.mem_address = sum_imm;
                    case (op)
                        mre_pkg::OpLb: begin
                            res.mem_op = mre_pkg::MemLb;
                            res.reg_write = mre_pkg::WrDelayed;
                            res.dest_index = rt;
                        end
                        mre_pkg::OpLbu: begin
                            res.mem_op = mre_pkg::MemLbu;
                            res.reg_write = mre_pkg::WrDelayed;
                            res.dest_index = rt;
                        end
                        mre_pkg::OpLw: begin
                            res.mem_op = mre_pkg::MemLw;
                            res.reg_write = mre_pkg::WrDelayed;
                            res.dest_index = rt;
                        end
                        mre_pkg::OpSb: begin
                            res.mem_op = mre_pkg::MemSb;
                            res.store_data = {24'd0, rtv[7:0]};
                        end
                        mre_pkg::OpSh: begin
                            res.mem_op = mre_pkg::MemSh;
                            res.store_data = {16'd0, rtv[15:0]};
                        end
                        default: begin
                            res.mem_op = mre_pkg::MemSw;
                            res.store_data = rtv;
                        end
                    endcase
                end
            end
            default: res.unhandled = 1'b1;
        endcase
    end

    always_comb begin
        n_hi    = r_hi;
        n_lo    = r_lo;
        hilo_we = 1'b0;
        if (div_st.done) begin
            n_hi = div_r;
            n_lo = div_q;
            hilo_we = 1'b1;
        end else if (accept && (is_div || is_divu)) begin
            if (rtv == '0) begin
                n_hi = rsv;
                n_lo = nneg ? 32'd1 : mre_pkg::AllOnes;
                hilo_we = 1'b1;
            end else if (ovf) begin
                n_hi = '0;
                n_lo = mre_pkg::SignBit;
                hilo_we = 1'b1;
            end
        end
    end

    mre_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (abs_n),
        .i_divisor  (abs_d),
        .i_neg_quot (nneg != dneg),
        .i_neg_rem  (nneg),
        .o_status   (div_st),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi        <= '0;
            r_lo        <= '0;
            r_status    <= '0;
            r_cause     <= '0;
            r_epc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_hi <= n_hi;
            r_lo <= n_lo;
            if (accept && op == mre_pkg::OpCop0 && rs == mre_pkg::CopMt
                && rd == mre_pkg::CopStatus) begin
                r_status <= rtv;
            end
            if (i_cfg_we && i_cfg_index == mre_pkg::CfgCause) r_cause <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == mre_pkg::CfgEpc)   r_epc   <= i_cfg_data;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) r_out <= res;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.beat  = r_out;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !div_st.busy)
        else $error("instruction accepted while the divider is busy");
    a_hilo_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !hilo_we |=> $stable(r_hi) && $stable(r_lo))
        else $error("HI or LO changed without a divide");
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out))
        else $error("stalled result was lost or changed");
endmodule

>>> verif/mre_exec_checker.sv
`timescale 1ns / 1ps
// Checker for the execute unit: watches the instruction and result channels,
// predicts each result beat and compares it. Depends on mre_pkg and mre_if.
module mre_exec_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mre_in_if.sink      i_in,
    mre_out_if.sink     i_out,
    input  logic        i_cfg_we,
    input  logic [mre_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [mre_pkg::WordW-1:0]   i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    logic [31:0]        cause_reg, epc_reg, hi_reg, lo_reg, status_reg;
    mre_pkg::t_out_beat result_queue[$];

    assign o_pending = result_queue.size();

    function automatic logic [31:0] sext16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Signed or unsigned divide with the divide-by-zero and overflow results.
    function automatic void run_divide(logic is_signed, logic [31:0] n, logic [31:0] d);
        logic [31:0] an, ad, q, r;
        if (d == 0) begin
            hi_reg = n;
            lo_reg = (is_signed && n[31]) ? 32'd1 : mre_pkg::AllOnes;
        end else if (!is_signed) begin
            hi_reg = n % d;
            lo_reg = n / d;
        end else if (n == mre_pkg::SignBit && d == mre_pkg::AllOnes) begin
            hi_reg = 0;
            lo_reg = mre_pkg::SignBit;
        end else begin
            an = n[31] ? -n : n;
            ad = d[31] ? -d : d;
            q = an / ad;
            r = an % ad;
            hi_reg = n[31] ? -r : r;
            lo_reg = (n[31] != d[31]) ? -q : q;
        end
    endfunction

    function automatic mre_pkg::t_out_beat execute_instr(mre_pkg::t_in_beat b);
        mre_pkg::t_out_beat o;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sh;
        logic [31:0] simm, btarget, jtarget;
        op = b.instr_word[31:26];
        rs = b.instr_word[25:21];
        rt = b.instr_word[20:16];
        rd = b.instr_word[15:11];
        sh = b.instr_word[10:6];
        fn = b.instr_word[5:0];
        simm = sext16(b.instr_word[15:0]);
        btarget = b.next_pc + (simm << 2) - 32'd4;
        jtarget = (b.next_pc & mre_pkg::SegmentMask) | {4'd0, b.instr_word[25:0], 2'd0};
        o = '0;
        o.new_next_pc = b.next_pc;
        case (op)
            mre_pkg::OpSpecial: begin
                o.reg_write = mre_pkg::WrNow;
                o.dest_index = rd;
                case (fn)
                    mre_pkg::FnSll: o.dest_value = b.rt_value << sh;
                    mre_pkg::FnSrl: o.dest_value = b.rt_value >> sh;
                    mre_pkg::FnSra: o.dest_value = $signed(b.rt_value) >>> sh;
                    mre_pkg::FnJr: begin
                        o.reg_write = mre_pkg::WrNone;
                        o.dest_index = 0;
                        o.new_next_pc = b.rs_value;
                    end
                    mre_pkg::FnJalr: begin
                        o.dest_value = b.next_pc;
                        o.new_next_pc = b.rs_value;
                    end
                    mre_pkg::FnSyscall: begin
                        o.reg_write = mre_pkg::WrNone;
                        o.dest_index = 0;
                    end
                    mre_pkg::FnMfhi: o.dest_value = hi_reg;
                    mre_pkg::FnMflo: o.dest_value = lo_reg;
                    mre_pkg::FnDiv, mre_pkg::FnDivu: begin
                        o.reg_write = mre_pkg::WrNone;
                        o.dest_index = 0;
                        run_divide(fn == mre_pkg::FnDiv, b.rs_value, b.rt_value);
                    end
                    mre_pkg::FnAdd, mre_pkg::FnAddu: o.dest_value = b.rs_value + b.rt_value;
                    mre_pkg::FnSubu: o.dest_value = b.rs_value - b.rt_value;
                    mre_pkg::FnAnd: o.dest_value = b.rs_value & b.rt_value;
                    mre_pkg::FnOr: o.dest_value = b.rs_value | b.rt_value;
                    mre_pkg::FnSlt:
                        o.dest_value = {31'd0, $signed(b.rs_value) < $signed(b.rt_value)};
                    mre_pkg::FnSltu: o.dest_value = {31'd0, b.rs_value < b.rt_value};
                    default: begin
                        o.reg_write = mre_pkg::WrNone;
                        o.dest_index = 0;
                        o.unhandled = 1'b1;
                    end
                endcase
            end
            mre_pkg::OpRegimm: begin
                if (b.instr_word[20]) begin
                    o.reg_write = mre_pkg::WrNow;
                    o.dest_index = mre_pkg::LinkReg;
                    o.dest_value = b.next_pc;
                end
                if (b.rs_value[31] != b.instr_word[16]) o.new_next_pc = btarget;
            end
            mre_pkg::OpJ: o.new_next_pc = jtarget;
            mre_pkg::OpJal: begin
                o.reg_write = mre_pkg::WrNow;
                o.dest_index = mre_pkg::LinkReg;
                o.dest_value = b.next_pc;
                o.new_next_pc = jtarget;
            end
            mre_pkg::OpBeq: if (b.rs_value == b.rt_value) o.new_next_pc = btarget;
            mre_pkg::OpBne: if (b.rs_value != b.rt_value) o.new_next_pc = btarget;
            mre_pkg::OpBlez:
                if (b.rs_value[31] || b.rs_value == 0) o.new_next_pc = btarget;
            mre_pkg::OpBgtz:
                if (!b.rs_value[31] && b.rs_value != 0) o.new_next_pc = btarget;
            mre_pkg::OpAddi, mre_pkg::OpAddiu, mre_pkg::OpSlti, mre_pkg::OpSltiu,
            mre_pkg::OpAndi, mre_pkg::OpOri, mre_pkg::OpLui: begin
                o.reg_write = mre_pkg::WrNow;
                o.dest_index = rt;
                case (op)
                    mre_pkg::OpSlti:
                        o.dest_value = {31'd0, $signed(b.rs_value) < $signed(simm)};
                    mre_pkg::OpSltiu: o.dest_value = {31'd0, b.rs_value < simm};
                    mre_pkg::OpAndi:
                        o.dest_value = b.rs_value & {16'd0, b.instr_word[15:0]};
                    mre_pkg::OpOri:
                        o.dest_value = b.rs_value | {16'd0, b.instr_word[15:0]};
                    mre_pkg::OpLui: o.dest_value = {b.instr_word[15:0], 16'd0};
                    default: o.dest_value = b.rs_value + simm;
                endcase
            end
            mre_pkg::OpCop0: begin
                if (rs == mre_pkg::CopMf) begin
                    o.reg_write = mre_pkg::WrDelayed;
                    o.dest_index = rt;
                    case (rd)
                        mre_pkg::CopStatus: o.dest_value = status_reg;
                        mre_pkg::CopCause: o.dest_value = cause_reg;
                        mre_pkg::CopEpc: o.dest_value = epc_reg;
                        default: o.dest_value = mre_pkg::NoCopReg;
                    endcase
                end else if (rs == mre_pkg::CopMt) begin
                    if (rd == mre_pkg::CopStatus) status_reg = b.rt_value;
                end else begin
                    o.unhandled = 1'b1;
                end
            end
            mre_pkg::OpLb, mre_pkg::OpLw, mre_pkg::OpLbu,
            mre_pkg::OpSb, mre_pkg::OpSh, mre_pkg::OpSw: begin
                if (!status_reg[mre_pkg::IsolateBit]) begin
                    o.mem_address = b.rs_value + simm;
                    case (op)
                        mre_pkg::OpLb: o.mem_op = mre_pkg::MemLb;
                        mre_pkg::OpLbu: o.mem_op = mre_pkg::MemLbu;
                        mre_pkg::OpLw: o.mem_op = mre_pkg::MemLw;
                        mre_pkg::OpSb: begin
                            o.mem_op = mre_pkg::MemSb;
                            o.store_data = {24'd0, b.rt_value[7:0]};
                        end
                        mre_pkg::OpSh: begin
                            o.mem_op = mre_pkg::MemSh;
                            o.store_data = {16'd0, b.rt_value[15:0]};
                        end
                        default: begin
                            o.mem_op = mre_pkg::MemSw;
                            o.store_data = b.rt_value;
                        end
                    endcase
                    if (op == mre_pkg::OpLb || op == mre_pkg::OpLbu || op == mre_pkg::OpLw) begin
                        o.reg_write = mre_pkg::WrDelayed;
                        o.dest_index = rt;
                    end
                end
            end
            default: o.unhandled = 1'b1;
        endcase
        return o;
    endfunction

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, actual %h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        mre_pkg::t_out_beat e, a;
        if (!i_rst_n) begin
            cause_reg <= 0;
            epc_reg <= 0;
            hi_reg = 0;
            lo_reg = 0;
            status_reg = 0;
            o_fail_count = 0;
            result_queue.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == mre_pkg::CfgCause) cause_reg <= i_cfg_data;
                else if (i_cfg_index == mre_pkg::CfgEpc) epc_reg <= i_cfg_data;
            end
            if (i_out.valid && i_out.ready) begin
                a = i_out.beat;
                if (result_queue.size() == 0) begin
                    $error("Result beat with no instruction outstanding");
                    o_fail_count++;
                end else begin
                    e = result_queue.pop_front();
                    compare_field("reg_write", e.reg_write, a.reg_write);
                    compare_field("dest_index", e.dest_index, a.dest_index);
                    compare_field("dest_value", e.dest_value, a.dest_value);
                    compare_field("mem_op", e.mem_op, a.mem_op);
                    compare_field("mem_address", e.mem_address, a.mem_address);
                    compare_field("store_data", e.store_data, a.store_data);
                    compare_field("new_next_pc", e.new_next_pc, a.new_next_pc);
                    compare_field("unhandled", e.unhandled, a.unhandled);
                end
            end
            if (i_in.valid && i_in.ready) result_queue.push_back(execute_instr(i_in.beat));
        end
    end
endmodule

>>> verif/mips_r3000_execute_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for the execute unit: clock, reset, instruction stimulus,
// result back-pressure and verdict. Depends on mre_pkg, mre_if, the unit and the checker.
module mips_r3000_execute_unit_test;
    localparam int RandomCount = 650;
    localparam int IdleLimit   = 2000;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic [mre_pkg::CfgIdxW-1:0] cfg_index;
    logic [mre_pkg::WordW-1:0]   cfg_data;
    int   fail_count, pending, idle_cycles;
    logic quiet_phase, hold_results;

    mre_in_if  instr_ch ();
    mre_out_if result_ch ();

    mips_r3000_execute_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(instr_ch.sink), .o_out(result_ch.source),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    mre_exec_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(instr_ch.sink), .i_out(result_ch.sink),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return mre_pkg::AllOnes;
            2: return mre_pkg::SignBit;
            3: return $urandom_range(0, 8);
            default: return $urandom;
        endcase
    endfunction

    // Mostly implemented opcodes with random fields, now and then a raw word.
    function automatic logic [31:0] pick_instr();
        logic [5:0] ops[22] = '{mre_pkg::OpSpecial, mre_pkg::OpSpecial, mre_pkg::OpRegimm,
            mre_pkg::OpJ, mre_pkg::OpJal, mre_pkg::OpBeq, mre_pkg::OpBne, mre_pkg::OpBlez,
            mre_pkg::OpBgtz, mre_pkg::OpAddi, mre_pkg::OpAddiu, mre_pkg::OpSlti,
            mre_pkg::OpSltiu, mre_pkg::OpAndi, mre_pkg::OpOri, mre_pkg::OpLui,
            mre_pkg::OpCop0, mre_pkg::OpLb, mre_pkg::OpLw, mre_pkg::OpLbu, mre_pkg::OpSb,
            mre_pkg::OpSw};
        logic [5:0] fns[17] = '{mre_pkg::FnSll, mre_pkg::FnSrl, mre_pkg::FnSra,
            mre_pkg::FnJr, mre_pkg::FnJalr, mre_pkg::FnSyscall, mre_pkg::FnMfhi,
            mre_pkg::FnMflo, mre_pkg::FnDiv, mre_pkg::FnDivu, mre_pkg::FnAdd,
            mre_pkg::FnAddu, mre_pkg::FnSubu, mre_pkg::FnAnd, mre_pkg::FnOr,
            mre_pkg::FnSlt, mre_pkg::FnSltu};
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 15) == 0) return w;
        w[31:26] = ops[$urandom_range(0, 21)];
        if ($urandom_range(0, 9) == 0) w[31:26] = mre_pkg::OpSh;
        if (w[31:26] == mre_pkg::OpSpecial) w[5:0] = fns[$urandom_range(0, 16)];
        if (w[31:26] == mre_pkg::OpCop0 && $urandom_range(0, 7) != 0) begin
            w[25:21] = $urandom_range(0, 1) ? mre_pkg::CopMf : mre_pkg::CopMt;
            if ($urandom_range(0, 2) != 0)
                w[15:11] = mre_pkg::CopStatus + 5'($urandom_range(0, 2));
            // Clear the rt field of most MTC0 words.
            if (w[25:21] == mre_pkg::CopMt && $urandom_range(0, 3) != 0) w[20:16] = 5'd0;
        end
        return w;
    endfunction

    task automatic send_instr(logic [31:0] w, logic [31:0] a, logic [31:0] b,
                              logic [31:0] npc);
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            instr_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        instr_ch.valid <= 1'b1;
        instr_ch.beat <= '{w, a, b, npc};
        @(posedge i_clk);
        while (!instr_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        instr_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [mre_pkg::CfgIdxW-1:0] idx, logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            @(negedge i_clk);
            if (hold_results) result_ch.ready <= 1'b0;
            else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge i_clk);
            end else result_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (instr_ch.valid && instr_ch.ready) ||
            (result_ch.valid && result_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [31:0] cfg_vals[4];
        cfg_vals = '{32'd0, mre_pkg::AllOnes, 32'h1234_5678, mre_pkg::SignBit};
        i_rst_n = 1'b0;
        instr_ch.valid = 1'b0;
        instr_ch.beat = '0;
        result_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet_phase = 1'b0;
        hold_results = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_cfg(mre_pkg::CfgCause, 32'hCAFE_0013);
        write_cfg(mre_pkg::CfgEpc, 32'h0000_0014);

        // Directed: divide corner cases, other ops, links, COP0 moves, isolate cache.
        send_instr({mre_pkg::OpSpecial, 20'd0, mre_pkg::FnDiv}, 32'd7, 32'd0, 32'h100);
        send_instr({mre_pkg::OpSpecial, 10'd0, 5'd3, 5'd0, mre_pkg::FnMflo}, 0, 0, 32'h104);
        send_instr({mre_pkg::OpSpecial, 20'd0, mre_pkg::FnDiv}, mre_pkg::SignBit, 32'd0,
                   32'h108);
        send_instr({mre_pkg::OpSpecial, 10'd0, 5'd3, 5'd0, mre_pkg::FnMflo}, 0, 0, 32'h10C);
        send_instr({mre_pkg::OpSpecial, 20'd0, mre_pkg::FnDiv}, mre_pkg::SignBit,
                   mre_pkg::AllOnes, 32'h110);
        send_instr({mre_pkg::OpSpecial, 10'd0, 5'd4, 5'd0, mre_pkg::FnMfhi}, 0, 0, 32'h114);
        send_instr({mre_pkg::OpSpecial, 20'd0, mre_pkg::FnDivu}, mre_pkg::AllOnes, 32'd0,
                   32'h118);
        send_instr({mre_pkg::OpSpecial, 10'd0, 5'd4, 5'd0, mre_pkg::FnMflo}, 0, 0, 32'h11C);
        send_instr({mre_pkg::OpSpecial, 20'd0, mre_pkg::FnDiv}, 32'hFFFF_FFF9, 32'd2,
                   32'h120);
        send_instr({mre_pkg::OpSpecial, 10'd0, 5'd4, 5'd0, mre_pkg::FnMfhi}, 0, 0, 32'h124);
        send_instr({mre_pkg::OpSpecial, 20'd0, mre_pkg::FnAdd}, 32'h7FFF_FFFF, 32'd1,
                   32'h128);
        send_instr({mre_pkg::OpAddi, 10'd0, 16'h8000}, mre_pkg::SignBit, 0, 32'h12C);
        send_instr({mre_pkg::OpSpecial, 20'd0, mre_pkg::FnSyscall}, 0, 0, 32'h130);
        send_instr({mre_pkg::OpSpecial, 20'd0, 6'h3F}, 1, 2, 32'h134);
        send_instr({mre_pkg::OpRegimm, 5'd1, 5'h11, 16'hFFFF}, mre_pkg::SignBit, 0,
                   32'hF000_0000);
        send_instr({mre_pkg::OpRegimm, 5'd1, 5'h10, 16'h7FFF}, mre_pkg::SignBit, 0, 32'h200);
        send_instr({mre_pkg::OpJal, 26'h3FF_FFFF}, 0, 0, mre_pkg::AllOnes);
        send_instr({mre_pkg::OpCop0, mre_pkg::CopMf, 5'd2, mre_pkg::CopCause, 11'd0}, 0, 0,
                   32'h204);
        send_instr({mre_pkg::OpCop0, mre_pkg::CopMf, 5'd2, mre_pkg::CopEpc, 11'd0}, 0, 0,
                   32'h208);
        send_instr({mre_pkg::OpCop0, mre_pkg::CopMf, 5'd2, 5'd3, 11'd0}, 0, 0, 32'h20C);
        send_instr({mre_pkg::OpCop0, mre_pkg::CopMt, 5'd2, mre_pkg::CopStatus, 11'd0}, 0,
                   32'h0001_0000, 32'h210);
        send_instr({mre_pkg::OpSw, 10'd0, 16'h8000}, 32'h10, mre_pkg::AllOnes, 32'h214);
        send_instr({mre_pkg::OpCop0, mre_pkg::CopMf, 5'd2, mre_pkg::CopStatus, 11'd0}, 0, 0,
                   32'h218);
        send_instr({mre_pkg::OpCop0, mre_pkg::CopMt, 5'd2, mre_pkg::CopStatus, 11'd0}, 0,
                   32'd0, 32'h21C);
        send_instr({mre_pkg::OpSh, 10'd0, 16'h7FFF}, mre_pkg::AllOnes, mre_pkg::AllOnes,
                   32'h220);

        for (int i = 0; i < RandomCount; i++) begin
            if (i % 160 == 0) begin
                wait_drained();
                write_cfg(mre_pkg::CfgCause, cfg_vals[(i / 160) % 4]);
                write_cfg(mre_pkg::CfgEpc, i == 0 ? $urandom : cfg_vals[3 - (i / 160) % 4]);
            end
            if (i == 300) begin
                fork
                    begin
                        hold_results = 1'b1;
                        repeat (60) @(negedge i_clk);
                        hold_results = 1'b0;
                    end
                join_none
            end
            if (i == 400) wait_drained();
            if (i == RandomCount - 80) quiet_phase = 1'b1;
            send_instr(pick_instr(), pick_value(), pick_value(), $urandom);
        end

        wait_drained();
        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
